FILE: sv/hcms_pkg.sv
// Shared types and constants for the Hilbert-curve matrix store.
// No dependencies; imported by every module of the block but hcms_ram.
package hcms_pkg;

  localparam int SIZE_W     = 7;    // matrix size register
  localparam int POS_W      = 7;    // internal cursor coordinate, holds any position below a size
  localparam int ROW_W      = 6;    // row and column fields on the ports
  localparam int REQ_W      = 3;
  localparam int IDX_OUT_W  = 12;
  localparam int WORD_W     = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_TELEPORT = 3'd0,
    REQ_LEFT     = 3'd1,
    REQ_RIGHT    = 3'd2,
    REQ_UP       = 3'd3,
    REQ_DOWN     = 3'd4,
    REQ_WRITE    = 3'd5
  } req_code_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [ROW_W-1:0]         target_row;
    logic [ROW_W-1:0]         target_col;
    logic signed [WORD_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]         cursor_row;
    logic [ROW_W-1:0]         cursor_col;
    logic [IDX_OUT_W-1:0]     curve_index;
    logic signed [WORD_W-1:0] cursor_value;
    logic                     accepted;
  } resp_t;

  // controller -> datapath
  typedef struct packed {
    logic cap_en;     // latch the incoming request
    logic map_en;     // register target, bounds and curve index
    logic access_en;  // update cursor, issue memory read or write
    logic finish_en;  // refresh cache and load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ok;         // request in range, valid while mapping
  } dp_sts_t;

endpackage

FILE: sv/hcms_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module hcms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/hcms_ctrl.sv
// Request sequencer: capture, map, memory access, finish into output register.
// Depends on hcms_pkg.
module hcms_ctrl
  import hcms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_ACCESS,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // output register can take a new result if empty or being drained
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.cap_en    = (state_r == S_IDLE) && in_valid;
    cmd.map_en    = (state_r == S_MAP);
    cmd.access_en = (state_r == S_ACCESS);
    cmd.finish_en = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish_en) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          // rejected requests have nothing to touch
          state_r <= sts.ok ? S_ACCESS : S_FINISH;
        end
        S_ACCESS: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_maps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MAP))
    else $error("accepted request did not enter mapping");

  a_reject_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP && !sts.ok) |=> (state_r == S_FINISH))
    else $error("rejected request went to memory access");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_en |=> (out_valid && state_r == S_IDLE))
    else $error("finished request not presented");

endmodule

FILE: sv/hcms_dp.sv
// Datapath: cursor, size register, Hilbert mapping, cell store and output register.
// Depends on hcms_pkg and hcms_ram.
module hcms_dp
  import hcms_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  req_t              in_req,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output resp_t             out_resp
);

  localparam int EFF_MAX = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam int LVL_MAX = $clog2(EFF_MAX);
  localparam int LVL_W   = $clog2(LVL_MAX + 1);
  localparam int IDX_W   = 2 * LVL_MAX;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(CELLS);

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] e;
    if (n == '0) begin
      e = SIZE_W'(1);
    end else if (n > SIZE_W'(EFF_MAX)) begin
      e = SIZE_W'(EFF_MAX);
    end else begin
      e = n;
    end
    return e;
  endfunction

  // curve order: bits needed for the next power of two at or above n
  function automatic logic [LVL_W-1:0] levels_of(input logic [SIZE_W-1:0] n);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int k = 0; k < LVL_MAX; k++) begin
      if ((SIZE_W+1)'(1 << k) < {1'b0, n}) begin
        l = l + LVL_W'(1);
      end
    end
    return l;
  endfunction

  function automatic logic [IDX_W-1:0] hilbert(input logic [LVL_MAX-1:0] r_in,
                                               input logic [LVL_MAX-1:0] c_in,
                                               input logic [LVL_W-1:0]   lvl);
    logic [LVL_MAX-1:0] r;
    logic [LVL_MAX-1:0] c;
    logic [LVL_MAX-1:0] t;
    logic [IDX_W+1:0]   d;
    logic [1:0]         q;
    r = r_in;
    c = c_in;
    d = '0;
    for (int i = LVL_MAX - 1; i >= 0; i--) begin
      if (i < int'(lvl)) begin
        t = r;
        q = 2'd0;
        // only bits below i matter from here on, so no masking
        case ({r[i], c[i]})
          2'b00: begin
            r = c;
            c = t;
            q = 2'd0;
          end
          2'b01: q = 2'd1;
          2'b11: q = 2'd2;
          default: begin
            r = ~c;
            c = ~t;
            q = 2'd3;
          end
        endcase
        d = {d[IDX_W-1:0], q};
      end
    end
    return d[IDX_W-1:0];
  endfunction

  // size register
  logic [SIZE_W-1:0] n_r;
  logic [LVL_W-1:0]  lvl_r;

  // cursor and cache
  logic [POS_W-1:0]  row_r, col_r;
  logic [IDX_W-1:0]  curve_r;
  logic [WORD_W-1:0] cache_r;

  // request pipeline
  req_t              req_r;
  logic [POS_W-1:0]  tgt_row_r, tgt_col_r;
  logic [IDX_W-1:0]  h_r;
  logic              ok_r, in_mem_r, is_write_r;
  resp_t             out_r;

  // mapping
  logic [POS_W-1:0]  tr, tc;
  logic              cand, in_bounds, is_write, in_mem, ok;
  logic [IDX_W-1:0]  h;

  always_comb begin
    tr       = row_r;
    tc       = col_r;
    cand     = 1'b0;
    is_write = 1'b0;
    case (req_r.req_type)
      REQ_TELEPORT: begin
        tr   = {1'b0, req_r.target_row};
        tc   = {1'b0, req_r.target_col};
        cand = 1'b1;
      end
      REQ_LEFT: begin
        tc   = col_r - POS_W'(1);
        cand = (col_r != '0);
      end
      REQ_RIGHT: begin
        tc   = col_r + POS_W'(1);
        cand = 1'b1;
      end
      REQ_UP: begin
        tr   = row_r - POS_W'(1);
        cand = (row_r != '0);
      end
      REQ_DOWN: begin
        tr   = row_r + POS_W'(1);
        cand = 1'b1;
      end
      REQ_WRITE: begin
        tr       = {1'b0, req_r.target_row};
        tc       = {1'b0, req_r.target_col};
        cand     = 1'b1;
        is_write = 1'b1;
      end
      default: begin
        cand = 1'b0;
      end
    endcase
    in_bounds = cand && (tr < n_r) && (tc < n_r);
    h         = hilbert(tr[LVL_MAX-1:0], tc[LVL_MAX-1:0], lvl_r);
    in_mem    = 64'(h) < 64'(CELLS);
    // a move off the stored range still succeeds and caches zero
    ok        = in_bounds && (!is_write || in_mem);
  end

  assign sts.ok = ok;

  // memory
  logic                  ram_we, ram_re;
  logic [IDX_W+AW-1:0]   h_ext;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH+WORD_W-1:0] wd_ext;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH+WORD_W-1:0] rd_ext;

  assign h_ext    = {AW'(0), h_r};
  assign ram_addr = h_ext[AW-1:0];
  assign wd_ext   = {DATA_WIDTH'(0), $unsigned(req_r.write_data)};
  assign rd_ext   = {WORD_W'(0), ram_rdata};
  assign ram_we   = cmd.access_en && ok_r && is_write_r;
  assign ram_re   = cmd.access_en && ok_r && !is_write_r && in_mem_r;

  hcms_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (wd_ext[DATA_WIDTH-1:0]),
    .rdata (ram_rdata)
  );

  logic [WORD_W-1:0]          cache_nxt;
  logic [IDX_W+IDX_OUT_W-1:0] curve_ext;

  always_comb begin
    cache_nxt = cache_r;
    if (ok_r && !is_write_r) begin
      cache_nxt = in_mem_r ? rd_ext[WORD_W-1:0] : '0;
    end
  end

  assign curve_ext = {IDX_OUT_W'(0), curve_r};

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      req_r <= in_req;
    end
    if (cmd.map_en) begin
      tgt_row_r  <= tr;
      tgt_col_r  <= tc;
      h_r        <= h;
      in_mem_r   <= in_mem;
      is_write_r <= is_write;
    end
    if (cmd.finish_en) begin
      out_r.cursor_row   <= row_r[ROW_W-1:0];
      out_r.cursor_col   <= col_r[ROW_W-1:0];
      out_r.curve_index  <= curve_ext[IDX_OUT_W-1:0];
      out_r.cursor_value <= cache_nxt;
      out_r.accepted     <= ok_r;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= eff_size(SIZE_RESET);
      lvl_r   <= levels_of(eff_size(SIZE_RESET));
      row_r   <= '0;
      col_r   <= '0;
      curve_r <= '0;
      cache_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n_r   <= eff_size(cfg_wr_data);
        lvl_r <= levels_of(eff_size(cfg_wr_data));
      end
      if (cmd.map_en) begin
        ok_r <= ok;
      end
      if (cmd.access_en && ok_r && !is_write_r) begin
        row_r   <= tgt_row_r;
        col_r   <= tgt_col_r;
        curve_r <= h_r;
      end
      if (cmd.finish_en) begin
        cache_r <= cache_nxt;
      end
    end
  end

  assign out_resp = out_r;

  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !cmd.access_en) |=> ($stable(row_r) && $stable(col_r) && $stable(curve_r)))
    else $error("cursor moved outside memory access");

  a_cache_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !cmd.finish_en) |=> $stable(cache_r))
    else $error("cache changed outside finish");

  a_write_in_mem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.map_en |=> !(ok_r && is_write_r && !in_mem_r))
    else $error("accepted write outside the cell store");

endmodule

FILE: sv/hilbert_curve_matrix_store_top.sv
// Hilbert-curve matrix store with cursor: top level.
// A request runs in turn through the capture, map, RAM access and finish steps, and its result
// is registered at finish; a rejected request skips the RAM access. A new request is taken only
// after the last one has finished. A waiting result does not block the next request.
// Reset (rst_n low, synchronous): cursor, curve index and cache to zero, size to 64;
// cell store contents are not cleared and read as whatever was last written.
module hilbert_curve_matrix_store_top
  import hcms_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output resp_t             out_resp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hcms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcms_dp #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .cmd         (cmd),
    .sts         (sts),
    .out_resp    (out_resp)
  );

endmodule

FILE: sim/hcms_view_checker.sv
// Result checker for the Hilbert-curve matrix store: mirrors cursor, cache and cell store,
// predicts each response on request acceptance and compares it on response acceptance.
// Depends on hcms_pkg for the request and response types.
module hcms_view_checker
  import hcms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  req_t              in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  resp_t             out_resp,
  output int                view_errors,
  output int                views_pending
);

  localparam int CELL_COUNT = 4096;

  logic [SIZE_W-1:0]        size_reg;
  int unsigned              cur_row;
  int unsigned              cur_col;
  logic [IDX_OUT_W-1:0]     cur_curve;
  logic signed [WORD_W-1:0] cached_word;
  logic signed [WORD_W-1:0] cells [0:CELL_COUNT-1];
  resp_t                    expected_views [$];

  function automatic int unsigned span_of(logic [SIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > 64) return 64;
    return 32'(sz);
  endfunction

  // one level per bit of the next power of two at or above n
  function automatic logic [IDX_OUT_W-1:0] hilbert_index_of(int unsigned r, int unsigned c,
                                                             int unsigned n);
    int unsigned side;
    int unsigned s;
    int unsigned d;
    int unsigned t;
    bit          rb;
    bit          cb;
    side = 1;
    while (side < n) side <<= 1;
    d = 0;
    for (s = side >> 1; s >= 1; s >>= 1) begin
      rb = (r & s) != 0;
      cb = (c & s) != 0;
      r &= s - 1;
      c &= s - 1;
      if (!rb && !cb) begin
        t = r;
        r = c;
        c = t;
      end else if (!rb && cb) begin
        d += 1;
      end else if (rb && !cb) begin
        t = r;
        r = s - 1 - c;
        c = s - 1 - t;
        d += 3;
      end else begin
        d += 2;
      end
      if (s > 1) d <<= 2;
    end
    return d[IDX_OUT_W-1:0];
  endfunction

  task automatic move_to(input int unsigned r, input int unsigned c, input int unsigned n,
                         output logic ok);
    logic [IDX_OUT_W-1:0] h;
    ok = 1'b0;
    if (r < n && c < n) begin
      h           = hilbert_index_of(r, c, n);
      cur_row     = r;
      cur_col     = c;
      cur_curve   = h;
      cached_word = cells[h];
      ok          = 1'b1;
    end
  endtask

  task automatic apply_request(input req_t rq, output resp_t rs);
    int unsigned n;
    int unsigned tr;
    int unsigned tc;
    logic        ok;
    n  = span_of(size_reg);
    tr = 32'(rq.target_row);
    tc = 32'(rq.target_col);
    ok = 1'b0;
    case (rq.req_type)
      REQ_TELEPORT: move_to(tr, tc, n, ok);
      REQ_LEFT:     if (cur_col > 0) move_to(cur_row, cur_col - 1, n, ok);
      REQ_RIGHT:    move_to(cur_row, cur_col + 1, n, ok);
      REQ_UP:       if (cur_row > 0) move_to(cur_row - 1, cur_col, n, ok);
      REQ_DOWN:     move_to(cur_row + 1, cur_col, n, ok);
      REQ_WRITE: begin
        // the cache is left alone, even for the cursor's own cell
        if (tr < n && tc < n) begin
          cells[hilbert_index_of(tr, tc, n)] = rq.write_data;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    rs.cursor_row   = cur_row[ROW_W-1:0];
    rs.cursor_col   = cur_col[ROW_W-1:0];
    rs.curve_index  = cur_curve;
    rs.cursor_value = cached_word;
    rs.accepted     = ok;
  endtask

  always @(posedge clk) begin
    resp_t want;
    resp_t fresh;
    if (!rst_n) begin
      size_reg    = SIZE_RESET;
      cur_row     = 0;
      cur_col     = 0;
      cur_curve   = '0;
      cached_word = '0;
      view_errors = 0;
      expected_views.delete();
    end else begin
      if (cfg_wr_en) size_reg = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          if (view_errors < 10)
            $display("unexpected response: row %0d col %0d idx %0d val %0d ok %0b",
                     out_resp.cursor_row, out_resp.cursor_col, out_resp.curve_index,
                     out_resp.cursor_value, out_resp.accepted);
          view_errors++;
        end else begin
          want = expected_views.pop_front();
          if (out_resp.cursor_row !== want.cursor_row ||
              out_resp.cursor_col !== want.cursor_col ||
              out_resp.curve_index !== want.curve_index ||
              out_resp.cursor_value !== want.cursor_value ||
              out_resp.accepted !== want.accepted) begin
            if (view_errors < 10)
              $display("mismatch: exp r%0d c%0d i%0d v%0d a%0b got r%0d c%0d i%0d v%0d a%0b",
                       want.cursor_row, want.cursor_col, want.curve_index,
                       want.cursor_value, want.accepted,
                       out_resp.cursor_row, out_resp.cursor_col, out_resp.curve_index,
                       out_resp.cursor_value, out_resp.accepted);
            view_errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_req, fresh);
        expected_views.push_back(fresh);
      end
    end
    views_pending <= expected_views.size();
  end

endmodule

FILE: sim/hilbert_curve_matrix_store_top_test.sv
// Testbench top for hilbert_curve_matrix_store_top: clock, reset, request and size stimulus,
// response back-pressure and the verdict. Depends on hcms_pkg and hcms_view_checker.
module hilbert_curve_matrix_store_top_test;
  import hcms_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 115;
  localparam int CELL_TOTAL  = 4096;
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  req_t              in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  resp_t             out_resp;

  int                view_errors;
  int                views_pending;
  int                cycle_count = 0;
  bit                no_idle = 1'b0;
  bit                hold_req = 1'b0;
  logic [SIZE_W-1:0] cur_size = SIZE_RESET;
  logic [SIZE_W-1:0] phase_sizes [0:10] = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd127, 7'd8,
                                            7'd17, 7'd33, 7'd0, 7'd64, 7'd5};
  // stimulus-side view of the cursor and of which cells hold a value
  int unsigned       drv_row = 0;
  int unsigned       drv_col = 0;
  bit                cell_known [0:CELL_TOTAL-1];

  always #10 clk = ~clk;

  hilbert_curve_matrix_store_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_resp   (out_resp)
  );

  hcms_view_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_resp     (out_resp),
    .view_errors  (view_errors),
    .views_pending(views_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic int unsigned size_span(logic [SIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > 64) return 64;
    return 32'(sz);
  endfunction

  function automatic int unsigned curve_of(int unsigned r, int unsigned c, int unsigned n);
    int unsigned side;
    int unsigned s;
    int unsigned d;
    int unsigned t;
    bit          rb;
    bit          cb;
    side = 1;
    while (side < n) side <<= 1;
    d = 0;
    for (s = side >> 1; s >= 1; s >>= 1) begin
      rb = (r & s) != 0;
      cb = (c & s) != 0;
      r &= s - 1;
      c &= s - 1;
      if (!rb && !cb) begin
        t = r;
        r = c;
        c = t;
      end else if (!rb && cb) begin
        d += 1;
      end else if (rb && !cb) begin
        t = r;
        r = s - 1 - c;
        c = s - 1 - t;
        d += 3;
      end else begin
        d += 2;
      end
      if (s > 1) d <<= 2;
    end
    return d;
  endfunction

  function automatic req_t make_req(logic [REQ_W-1:0] code, int unsigned r, int unsigned c,
                                    logic [WORD_W-1:0] data);
    req_t rq;
    rq.req_type   = code;
    rq.target_row = r[ROW_W-1:0];
    rq.target_col = c[ROW_W-1:0];
    rq.write_data = data;
    return rq;
  endfunction

  // mostly in-range targets so moves and writes land; the rest spans the whole field
  function automatic req_t random_req(int unsigned span);
    req_t        rq;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 14)      rq.req_type = REQ_TELEPORT;
    else if (roll < 30) rq.req_type = REQ_LEFT;
    else if (roll < 46) rq.req_type = REQ_RIGHT;
    else if (roll < 62) rq.req_type = REQ_UP;
    else if (roll < 78) rq.req_type = REQ_DOWN;
    else if (roll < 97) rq.req_type = REQ_WRITE;
    else                rq.req_type = $urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B;
    if ($urandom_range(4) == 0) begin
      rq.target_row = ROW_W'($urandom_range(63));
      rq.target_col = ROW_W'($urandom_range(63));
    end else begin
      rq.target_row = ROW_W'($urandom_range(span - 1));
      rq.target_col = ROW_W'($urandom_range(span - 1));
    end
    case ($urandom_range(15))
      0:       rq.write_data = 32'h7fffffff;
      1:       rq.write_data = 32'h80000000;
      2:       rq.write_data = '1;
      default: rq.write_data = $urandom;
    endcase
    return rq;
  endfunction

  // entered and left at a rising edge; valid stays up across back-to-back requests
  task automatic send_req(input req_t rq);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // a move onto a cell that holds nothing yet is preceded by a write to that cell
  task automatic issue(input req_t rq);
    int unsigned n;
    int unsigned tr;
    int unsigned tc;
    int unsigned h;
    bit          moves;
    n     = size_span(cur_size);
    tr    = drv_row;
    tc    = drv_col;
    moves = 1'b1;
    case (rq.req_type)
      REQ_TELEPORT: begin
        tr = 32'(rq.target_row);
        tc = 32'(rq.target_col);
      end
      REQ_LEFT: begin
        if (drv_col > 0) tc = drv_col - 1;
        else moves = 1'b0;
      end
      REQ_RIGHT: begin
        tc = drv_col + 1;
      end
      REQ_UP: begin
        if (drv_row > 0) tr = drv_row - 1;
        else moves = 1'b0;
      end
      REQ_DOWN: begin
        tr = drv_row + 1;
      end
      REQ_WRITE: begin
        moves = 1'b0;
        if (rq.target_row < n && rq.target_col < n)
          cell_known[curve_of(32'(rq.target_row), 32'(rq.target_col), n)] = 1'b1;
      end
      default: begin
        moves = 1'b0;
      end
    endcase
    if (moves && tr < n && tc < n) begin
      h = curve_of(tr, tc, n);
      if (!cell_known[h]) begin
        cell_known[h] = 1'b1;
        send_req(make_req(REQ_WRITE, tr, tc, $urandom));
      end
      drv_row = tr;
      drv_col = tc;
    end
    send_req(rq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (views_pending != 0);
    @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] sz);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    cur_size    = sz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // response side: random stall runs, plus one long hold-off on request
  initial begin
    int unsigned run;
    int unsigned roll;
    bit          level;
    bit          hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        roll = $urandom_range(99);
        if (no_idle) begin
          level = 1'b0;
          run   = $urandom_range(1, 20);
        end else if (roll < 60) begin
          level = 1'b0;
          run   = $urandom_range(1, 8);
        end else if (roll < 90) begin
          level = 1'b1;
          run   = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          run   = $urandom_range(8, 24);
        end
        out_stall <= level;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned       span;
    logic [SIZE_W-1:0] sz;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme words in the corners
    issue(make_req(REQ_WRITE, 0, 0, 32'h80000000));
    issue(make_req(REQ_WRITE, 63, 63, 32'h7fffffff));
    issue(make_req(REQ_WRITE, 0, 63, '1));
    issue(make_req(REQ_WRITE, 63, 0, '0));

    // edges of the full matrix
    issue(make_req(REQ_TELEPORT, 0, 0, 0));
    issue(make_req(REQ_UP, 0, 0, 0));
    issue(make_req(REQ_LEFT, 0, 0, 0));
    issue(make_req(REQ_TELEPORT, 63, 63, 0));
    issue(make_req(REQ_DOWN, 63, 63, 0));
    issue(make_req(REQ_RIGHT, 63, 63, 0));
    issue(make_req(REQ_LEFT, 0, 0, 0));
    issue(make_req(REQ_UP, 0, 0, 0));
    // write to the cursor cell is only seen after moving away and back
    issue(make_req(REQ_WRITE, 62, 62, 32'h7fffffff));
    issue(make_req(REQ_RIGHT, 0, 0, 0));
    issue(make_req(REQ_LEFT, 0, 0, 0));
    issue(make_req(REQ_TELEPORT, 63, 0, 0));
    issue(make_req(REQ_SPARE_A, 63, 63, '1));
    issue(make_req(REQ_SPARE_B, 63, 63, '1));

    // size zero behaves as a single cell
    set_size(7'd0);
    issue(make_req(REQ_TELEPORT, 0, 0, 0));
    issue(make_req(REQ_TELEPORT, 0, 1, 0));
    issue(make_req(REQ_RIGHT, 0, 0, 0));
    issue(make_req(REQ_DOWN, 0, 0, 0));
    issue(make_req(REQ_WRITE, 1, 0, 32'h12345678));
    issue(make_req(REQ_WRITE, 0, 0, 32'h80000000));
    issue(make_req(REQ_TELEPORT, 0, 0, 0));

    // oversize clamps to the full matrix
    set_size(7'd127);
    issue(make_req(REQ_TELEPORT, 63, 63, 0));

    // shrink with the cursor left outside the new bounds
    set_size(7'd5);
    issue(make_req(REQ_LEFT, 0, 0, 0));
    issue(make_req(REQ_TELEPORT, 4, 4, 0));
    issue(make_req(REQ_TELEPORT, 5, 0, 0));
    issue(make_req(REQ_WRITE, 0, 5, 32'h0badf00d));

    for (int ph = 0; ph < 11; ph++) begin
      sz = (ph == 10) ? SIZE_W'($urandom_range(4, 62)) : phase_sizes[ph];
      set_size(sz);
      no_idle = (ph == 3 || ph == 7);
      if (ph == 0) hold_req = 1'b1;
      span = size_span(cur_size);
      for (int k = 0; k < PHASE_ITEMS; k++)
        issue(random_req(span));
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (view_errors == 0 && views_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
